FILE: src/aar_pkg.sv
package aar_pkg;

  localparam int FRAC_BITS     = 14;
  localparam int CORDIC_STAGES = 16;
  localparam int INT_BITS      = 30;
  localparam int CW            = 33;  // cordic vector width, q2.30 plus growth
  localparam int ZW            = 33;  // residual width, 2^32 per turn
  localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } aar_in_t;

  typedef struct packed {
    logic signed [15:0] m_row0_col0;
    logic signed [15:0] m_row0_col1;
    logic signed [15:0] m_row0_col2;
    logic signed [15:0] m_row1_col0;
    logic signed [15:0] m_row1_col1;
    logic signed [15:0] m_row1_col2;
    logic signed [15:0] m_row2_col0;
    logic signed [15:0] m_row2_col1;
    logic signed [15:0] m_row2_col2;
  } aar_out_t;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } aar_axis_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] k);
    logic signed [ZW-1:0] r;
    begin
      case (k)
        5'd0: r = 33'sd536870912;  5'd1: r = 33'sd316933406;
        5'd2: r = 33'sd167458907;  5'd3: r = 33'sd85004756;
        5'd4: r = 33'sd42667331;   5'd5: r = 33'sd21354465;
        5'd6: r = 33'sd10679838;   5'd7: r = 33'sd5340245;
        5'd8: r = 33'sd2670163;    5'd9: r = 33'sd1335087;
        5'd10: r = 33'sd667544;    5'd11: r = 33'sd333772;
        5'd12: r = 33'sd166886;    5'd13: r = 33'sd83443;
        5'd14: r = 33'sd41722;     5'd15: r = 33'sd20861;
        5'd16: r = 33'sd10430;     5'd17: r = 33'sd5215;
        5'd18: r = 33'sd2608;      5'd19: r = 33'sd1304;
        5'd20: r = 33'sd652;       5'd21: r = 33'sd326;
        5'd22: r = 33'sd163;       5'd23: r = 33'sd81;
        5'd24: r = 33'sd41;        5'd25: r = 33'sd20;
        5'd26: r = 33'sd10;        5'd27: r = 33'sd5;
        5'd28: r = 33'sd3;         5'd29: r = 33'sd1;
        5'd30: r = 33'sd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

FILE: src/axis_angle_rotation_matrix.sv
// axis-angle to 3x3 rotation matrix, rodrigues formula in fixed point
// input channel: start with in_item (angle as binary angle, 65536 per turn,
//   axis components q1.14); a transfer happens when start is high and busy low
// busy is always low: the block takes one item every clock cycle
// result channel: out_valid strobes for one cycle with out_item holding the
//   nine q1.14 entries, saturated; the receiver cannot hold results off
// from transfer to strobe an item passes the cordic pipeline (one stage per
//   iteration, plus entry and sign fixup) and then four stages of products,
//   rounding and final saturation
// throughput: one item per cycle, results leave in input order
// reset: synchronous active-low rst_n clears the valid bits of all stages;
//   items in flight are dropped, data registers are not cleared
// no configuration and no state beyond the pipeline itself
module axis_angle_rotation_matrix (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  aar_pkg::aar_in_t  in_item,
  output logic              out_valid,
  output aar_pkg::aar_out_t out_item
);
  import aar_pkg::*;

  aar_axis_t            axis_in, axis_cs;
  logic                 cs_vld;
  logic signed [CW-1:0] c_w, s_w;

  // never stalls, every start is a transfer
  assign busy = 1'b0;

  assign axis_in.ax = in_item.axis_x;
  assign axis_in.ay = in_item.axis_y;
  assign axis_in.az = in_item.axis_z;

  // cosine and sine with the axis riding along
  aar_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start & ~busy),
    .in_angle (in_item.angle),
    .in_axis  (axis_in),
    .out_vld  (cs_vld),
    .out_c    (c_w),
    .out_s    (s_w),
    .out_axis (axis_cs)
  );

  // matrix entries
  aar_rodrigues u_rod (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (cs_vld),
    .in_c    (c_w),
    .in_s    (s_w),
    .in_axis (axis_cs),
    .out_vld (out_valid),
    .out_m   (out_item)
  );

endmodule

FILE: src/aar_cordic.sv
module aar_cordic (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic signed [15:0]           in_angle,
  input  aar_pkg::aar_axis_t           in_axis,
  output logic                         out_vld,
  output logic signed [aar_pkg::CW-1:0] out_c,
  output logic signed [aar_pkg::CW-1:0] out_s,
  output aar_pkg::aar_axis_t           out_axis
);
  import aar_pkg::*;

  localparam int N = CORDIC_STAGES;

  logic                 vld_r  [N+1];
  logic signed [CW-1:0] x_r    [N+1];
  logic signed [CW-1:0] y_r    [N+1];
  logic signed [ZW-1:0] z_r    [N+1];
  logic                 flip_r [N+1];
  aar_axis_t            axis_r [N+1];

  logic signed [16:0] ang_red;
  logic               flip0;

  always_comb begin
    ang_red = 17'(in_angle);
    flip0   = 1'b0;
    if (in_angle > 16'sd16384) begin
      ang_red = 17'(in_angle) - 17'sd32768;
      flip0   = 1'b1;
    end else if (in_angle < -16'sd16384) begin
      ang_red = 17'(in_angle) + 17'sd32768;
      flip0   = 1'b1;
    end
  end

  // stage 0 entry register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    x_r[0]    <= GAIN_Q30;
    y_r[0]    <= '0;
    z_r[0]    <= {ang_red, 16'd0};
    flip_r[0] <= flip0;
    axis_r[0] <= in_axis;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [4:0] K = 5'(i % 32);
    logic signed [CW-1:0] dx, dy;
    assign dx = y_r[i] >>> K;
    assign dy = x_r[i] >>> K;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      if (!z_r[i][ZW-1]) begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
        z_r[i+1] <= z_r[i] - atan_lut(K);
      end else begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
        z_r[i+1] <= z_r[i] + atan_lut(K);
      end
      flip_r[i+1] <= flip_r[i];
      axis_r[i+1] <= axis_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld_r[N];
    end
    out_c    <= flip_r[N] ? -x_r[N] : x_r[N];
    out_s    <= flip_r[N] ? -y_r[N] : y_r[N];
    out_axis <= axis_r[N];
  end

  logic unused_z;
  assign unused_z = ^z_r[N];

endmodule

FILE: src/aar_rodrigues.sv
module aar_rodrigues (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic signed [aar_pkg::CW-1:0] in_c,
  input  logic signed [aar_pkg::CW-1:0] in_s,
  input  aar_pkg::aar_axis_t            in_axis,
  output logic                          out_vld,
  output aar_pkg::aar_out_t             out_m
);
  import aar_pkg::*;

  localparam int SH = INT_BITS - FRAC_BITS;

  // stage a: pair products, omc
  logic                 va_r;
  logic signed [31:0]   pxx_r, pyy_r, pzz_r, pxy_r, pxz_r, pyz_r;
  logic signed [CW:0]   omc_r;
  logic signed [CW-1:0] ca_r, sa_r;
  aar_axis_t            axa_r;
  // stage b: full products
  logic                 vb_r;
  logic signed [65:0]   txx_r, tyy_r, tzz_r, txy_r, txz_r, tyz_r;
  logic signed [49:0]   sx_r, sy_r, sz_r;
  logic signed [CW-1:0] cb_r;
  // stage c: rounded terms
  logic                 vc_r;
  logic signed [37:0]   rxx_r, ryy_r, rzz_r, rxy_r, rxz_r, ryz_r;
  logic signed [35:0]   rsx_r, rsy_r, rsz_r;
  logic signed [CW-1:0] cc_r;

  function automatic logic signed [37:0] rnd_p(input logic signed [65:0] v);
    logic signed [65:0] t;
    begin
      t = (v + (66'sd1 <<< (2*FRAC_BITS-1))) >>> (2*FRAC_BITS);
      return t[37:0];
    end
  endfunction

  function automatic logic signed [35:0] rnd_s(input logic signed [49:0] v);
    logic signed [49:0] t;
    begin
      t = (v + (50'sd1 <<< (FRAC_BITS-1))) >>> FRAC_BITS;
      return t[35:0];
    end
  endfunction

  function automatic logic signed [15:0] fin(input logic signed [39:0] v);
    logic signed [39:0] t;
    begin
      t = (v + (40'sd1 <<< (SH-1))) >>> SH;
      if (t > 40'sd32767)       return 16'sh7fff;
      else if (t < -40'sd32768) return 16'sh8000;
      else                      return t[15:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0; vb_r <= 1'b0; vc_r <= 1'b0; out_vld <= 1'b0;
    end else begin
      va_r <= in_vld; vb_r <= va_r; vc_r <= vb_r; out_vld <= vc_r;
    end
    pxx_r <= in_axis.ax * in_axis.ax;
    pyy_r <= in_axis.ay * in_axis.ay;
    pzz_r <= in_axis.az * in_axis.az;
    pxy_r <= in_axis.ax * in_axis.ay;
    pxz_r <= in_axis.ax * in_axis.az;
    pyz_r <= in_axis.ay * in_axis.az;
    omc_r <= (34'sd1 <<< INT_BITS) - 34'(in_c);
    ca_r  <= in_c;
    sa_r  <= in_s;
    axa_r <= in_axis;

    txx_r <= 66'(pxx_r) * 66'(omc_r);
    tyy_r <= 66'(pyy_r) * 66'(omc_r);
    tzz_r <= 66'(pzz_r) * 66'(omc_r);
    txy_r <= 66'(pxy_r) * 66'(omc_r);
    txz_r <= 66'(pxz_r) * 66'(omc_r);
    tyz_r <= 66'(pyz_r) * 66'(omc_r);
    sx_r  <= 50'(axa_r.ax) * 50'(sa_r);
    sy_r  <= 50'(axa_r.ay) * 50'(sa_r);
    sz_r  <= 50'(axa_r.az) * 50'(sa_r);
    cb_r  <= ca_r;

    rxx_r <= rnd_p(txx_r); ryy_r <= rnd_p(tyy_r); rzz_r <= rnd_p(tzz_r);
    rxy_r <= rnd_p(txy_r); rxz_r <= rnd_p(txz_r); ryz_r <= rnd_p(tyz_r);
    rsx_r <= rnd_s(sx_r);  rsy_r <= rnd_s(sy_r);  rsz_r <= rnd_s(sz_r);
    cc_r  <= cb_r;

    out_m.m_row0_col0 <= fin(40'(cc_r) + 40'(rxx_r));
    out_m.m_row0_col1 <= fin(40'(rxy_r) - 40'(rsz_r));
    out_m.m_row0_col2 <= fin(40'(rxz_r) + 40'(rsy_r));
    out_m.m_row1_col0 <= fin(40'(rxy_r) + 40'(rsz_r));
    out_m.m_row1_col1 <= fin(40'(cc_r) + 40'(ryy_r));
    out_m.m_row1_col2 <= fin(40'(ryz_r) - 40'(rsx_r));
    out_m.m_row2_col0 <= fin(40'(rxz_r) - 40'(rsy_r));
    out_m.m_row2_col1 <= fin(40'(ryz_r) + 40'(rsx_r));
    out_m.m_row2_col2 <= fin(40'(cc_r) + 40'(rzz_r));
  end

endmodule

FILE: src/aar_checker.sv
module aar_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input aar_pkg::aar_out_t out_item
);
  import aar_pkg::*;

  localparam int LAT = CORDIC_STAGES + 6;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after transfer");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without transfer");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("strobe right after reset");

  logic unused_m;
  assign unused_m = ^out_item;

endmodule

bind axis_angle_rotation_matrix aar_checker u_aar_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
